// ===== src/lvps_pkg.sv =====
// Package for the longest valid parenthesis span block.
// Holds the transaction payload types, the opener code and the size defaults.
// No dependencies.
package lvps_pkg;

  localparam int unsigned MAX_LEN_DEF = 1024;
  localparam int unsigned LONGEST_W   = 11;

  localparam logic [7:0]           OPEN_BYTE   = 8'h28;
  localparam logic [LONGEST_W-1:0] LONGEST_MAX = 11'h7FF;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [LONGEST_W-1:0] longest;
    logic                 too_long;
  } out_t;

  typedef struct packed {
    logic push;
    out_t res;
  } res_push_t;

endpackage

// ===== src/lvps_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
module lvps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/lvps_core.sv =====
// Stack engine: opener stack in lvps_ram, base mark, position and best span.
// Prefetches the entry below the top each cycle. Depends on lvps_pkg, lvps_ram.
module lvps_core
  import lvps_pkg::*;
#(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      acc,
  input  in_t       item,
  output res_push_t res_o
);

  localparam int unsigned PW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned EW = (PW > LONGEST_W) ? PW : LONGEST_W;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] base_r, base_nxt;
  logic [PW-1:0] best_r, best_nxt;
  logic          ovf_r, ovf_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] below;
  logic [PW-1:0] rd_tmp;
  logic [PW-1:0] span;
  logic [EW-1:0] best_ext;
  logic          proc;
  logic          is_open;

  lvps_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_LEN)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (below)
  );

  assign proc    = acc && (pos_r < PW'(MAX_LEN));
  assign is_open = (item.symbol == OPEN_BYTE);
  assign wr_addr = cnt_r[AW-1:0];
  assign wr_data = pos_r[AW-1:0];

  always_comb begin
    pos_nxt  = pos_r;
    cnt_nxt  = cnt_r;
    base_nxt = base_r;
    best_nxt = best_r;
    ovf_nxt  = ovf_r;
    wr_en    = 1'b0;
    span     = '0;
    best_ext = '0;
    res_o    = '0;
    if (proc) begin
      pos_nxt = pos_r + PW'(1);
      if (is_open) begin
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + PW'(1);
      end else if (cnt_r == '0) begin
        base_nxt = pos_r + PW'(1);
      end else begin
        cnt_nxt = cnt_r - PW'(1);
        if (cnt_r > PW'(1)) begin
          span = pos_r - PW'(below);
        end else begin
          span = pos_r + PW'(1) - base_r;
        end
        if (span > best_r) begin
          best_nxt = span;
        end
      end
    end
    if (acc && !proc) begin
      ovf_nxt = 1'b1;
    end
    if (acc && item.last) begin
      best_ext           = EW'(best_nxt);
      res_o.push         = 1'b1;
      res_o.res.too_long = ovf_nxt;
      res_o.res.longest  = (best_ext > EW'(LONGEST_MAX)) ? LONGEST_MAX
                                                         : best_ext[LONGEST_W-1:0];
      pos_nxt  = '0;
      cnt_nxt  = '0;
      base_nxt = '0;
      best_nxt = '0;
      ovf_nxt  = 1'b0;
    end
  end

  assign rd_tmp  = cnt_nxt - PW'(2);
  assign rd_addr = rd_tmp[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      cnt_r  <= '0;
      base_r <= '0;
      best_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      cnt_r  <= cnt_nxt;
      base_r <= base_nxt;
      best_r <= best_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  a_cnt_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= pos_r) else $error("stack depth exceeds position");

  a_base_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    base_r <= pos_r) else $error("base mark beyond position");

  a_best_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    best_r <= pos_r) else $error("best span beyond position");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    acc && item.last |=> pos_r == '0 && cnt_r == '0 && !ovf_r)
    else $error("state not cleared after last transaction");

endmodule

// ===== src/lvps_outq.sv =====
// Two-slot result queue: output register plus skid slot.
// Depends on lvps_pkg.
module lvps_outq
  import lvps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  res_push_t res_i,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output out_t      out_data
);

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  out_t out_r, out_nxt;
  out_t skid_r, skid_nxt;
  logic pop;

  assign pop = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = res_i.push;
        skid_nxt       = res_i.res;
      end else begin
        out_valid_nxt  = res_i.push;
        out_nxt        = res_i.res;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_i.push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res_i.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r) else $error("skid slot filled while output empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !res_i.push) else $error("result pushed into full queue");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_r))
    else $error("stalled result changed");

endmodule

// ===== src/longest_valid_paren_span.sv =====
// Longest valid parenthesis span over a byte stream, one character per transaction.
// Throughput: one character per cycle while the queue has room, set by the stack RAM's one write and one read port.
// The last transaction's result is registered into the output register, or the skid slot while that is occupied.
// Results queue in two slots; input stalls only while both slots are full.
// Reset: rst_n synchronous, active low; clears control state, no RAM clearing pass.
// Depends on lvps_pkg, lvps_core, lvps_outq.
module longest_valid_paren_span
  import lvps_pkg::*;
#(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  res_push_t res;
  logic      acc;

  assign acc = in_valid && in_ready;

  lvps_core #(
    .MAX_LEN (MAX_LEN)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .item  (in_data),
    .res_o (res)
  );

  lvps_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_i     (res),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
